[design/pal_pkg.sv]
// Shared types and constants for the positional array list.
`default_nettype none

package pal_pkg;

   localparam int CAPACITY = 64;

   // Field widths of the stream beats
   localparam int ACT_W = 2;
   localparam int POS_W = 7;
   localparam int VAL_W = 32;
   localparam int OUT_CNT_W = 7;

   localparam int REQ_BITS = ACT_W + POS_W + VAL_W;
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS = 1 + VAL_W + OUT_CNT_W;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   // Internal widths follow the capacity
   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   typedef enum logic [ACT_W-1:0] {
      ACT_GET    = 2'd0,
      ACT_INSERT = 2'd1,
      ACT_DELETE = 2'd2,
      ACT_CLEAR  = 2'd3
   } action_type;

   // Controller to datapath
   typedef struct packed {
      logic load_item;  // capture request beat
      logic init_idx;   // idx <= fill (insert) or pos (delete)
      logic rd_pos;     // read slot pos-1
      logic cap_rv;     // capture read data as result value
      logic rd_dn;      // read slot idx-1
      logic wr_dn;      // write slot idx with read data, idx--
      logic rd_up;      // read slot idx
      logic wr_up;      // write slot idx-1 with read data, idx++
      logic wr_value;   // write slot pos-1 with request value
      logic fill_inc;
      logic fill_dec;
      logic fill_clr;
      logic load_out;   // move result into the output register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      action_type act;
      logic       err;       // bad position or list full
      logic       more_dn;   // insert shift not done: idx >= pos
      logic       more_up;   // delete shift not done: idx < fill
      logic       out_busy;  // output register holds a beat not yet taken
   } stat_type;

endpackage

`default_nettype wire

[design/pal_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pal_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[design/pal_ctrl.sv]
// Sequencer for the positional array list: decode, shift loops, result hand-off.
`default_nettype none

module pal_ctrl
   import pal_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_tvalid,
   output logic          req_tready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_RD_WAIT,
      ST_INS_CHK,
      ST_INS_WR,
      ST_DEL_CHK,
      ST_DEL_WR,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.init_idx = 1'b1;
            if (stat.err) begin
               state_in = ST_FINISH;
            end else begin
               unique case (stat.act) inside
                  ACT_CLEAR: begin
                     cmd.fill_clr = 1'b1;
                     state_in     = ST_FINISH;
                  end
                  ACT_INSERT: begin
                     state_in = ST_INS_CHK;
                  end
                  ACT_GET, ACT_DELETE: begin
                     cmd.rd_pos = 1'b1;
                     state_in   = ST_RD_WAIT;
                  end
                  default: state_in = ST_FINISH;
               endcase
            end
         end
         ST_RD_WAIT: begin
            cmd.cap_rv = 1'b1;
            state_in   = (stat.act == ACT_DELETE) ? ST_DEL_CHK : ST_FINISH;
         end
         ST_INS_CHK: begin
            if (stat.more_dn) begin
               cmd.rd_dn = 1'b1;
               state_in  = ST_INS_WR;
            end else begin
               cmd.wr_value = 1'b1;
               cmd.fill_inc = 1'b1;
               state_in     = ST_FINISH;
            end
         end
         ST_INS_WR: begin
            cmd.wr_dn = 1'b1;
            state_in  = ST_INS_CHK;
         end
         ST_DEL_CHK: begin
            if (stat.more_up) begin
               cmd.rd_up = 1'b1;
               state_in  = ST_DEL_WR;
            end else begin
               cmd.fill_dec = 1'b1;
               state_in     = ST_FINISH;
            end
         end
         ST_DEL_WR: begin
            cmd.wr_up = 1'b1;
            state_in  = ST_DEL_CHK;
         end
         ST_FINISH: begin
            if (!stat.out_busy) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

   // Only one RAM write source per cycle
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.wr_dn, cmd.wr_up, cmd.wr_value}))
      else $error("pal_ctrl: more than one RAM write command");

   // A shift write always follows the read that feeds it
   a_wr_after_rd: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_dn || cmd.wr_up) |-> ($past(cmd.rd_dn) || $past(cmd.rd_up)))
      else $error("pal_ctrl: shift write without preceding read");

   // Length only changes while the item is being worked on, not while handing off
   a_no_fill_on_out: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !(cmd.fill_inc || cmd.fill_dec || cmd.fill_clr))
      else $error("pal_ctrl: length change during result hand-off");

endmodule

`default_nettype wire

[design/pal_dp.sv]
// Datapath: item registers, length, shift index, element RAM and output register.
`default_nettype none

module pal_dp
   import pal_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   input  wire cmd_type                cmd,
   output stat_type                    stat,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic      [RSP_TDATA_W-1:0] rsp_tdata
);

   action_type       act_ff;
   logic [POS_W-1:0] pos_ff;
   logic [VAL_W-1:0] val_ff;
   logic [VAL_W-1:0] rv_ff;
   logic             err_ff;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] idx_ff;
   logic             rsp_tvalid_ff;
   logic [RSP_BITS-1:0] rsp_data_ff;

   logic [CMP_W-1:0] pos_x, fill_x, idx_x;
   logic             err_rd, err_ins, err_now;
   logic [ADDR_W-1:0] pos_addr;

   logic              ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
   logic [VAL_W-1:0]  ram_wr_data, ram_rd_data;

   assign pos_x    = CMP_W'(pos_ff);
   assign fill_x   = CMP_W'(fill_ff);
   assign idx_x    = CMP_W'(idx_ff);
   assign pos_addr = ADDR_W'(pos_x - CMP_W'(1));

   assign err_rd  = (pos_ff == '0) || (pos_x > fill_x);
   assign err_ins = (fill_x >= CMP_W'(CAPACITY)) || (pos_ff == '0)
                    || (pos_x > fill_x + CMP_W'(1));

   always_comb begin
      case (act_ff) inside
         ACT_INSERT:         err_now = err_ins;
         ACT_GET, ACT_DELETE: err_now = err_rd;
         default:            err_now = 1'b0;
      endcase
   end

   assign stat.act      = act_ff;
   assign stat.err      = err_now;
   assign stat.more_dn  = (idx_x >= pos_x);
   assign stat.more_up  = (idx_x < fill_x);
   assign stat.out_busy = rsp_tvalid_ff && !rsp_tready;

   // RAM port steering
   assign ram_rd_en   = cmd.rd_pos || cmd.rd_dn || cmd.rd_up;
   assign ram_rd_addr = cmd.rd_pos ? pos_addr :
                        cmd.rd_dn  ? ADDR_W'(idx_x - CMP_W'(1)) : ADDR_W'(idx_ff);
   assign ram_wr_en   = cmd.wr_dn || cmd.wr_up || cmd.wr_value;
   assign ram_wr_addr = cmd.wr_dn ? ADDR_W'(idx_ff) :
                        cmd.wr_up ? ADDR_W'(idx_x - CMP_W'(1)) : pos_addr;
   assign ram_wr_data = cmd.wr_value ? val_ff : ram_rd_data;

   pal_ram #(
      .WIDTH (VAL_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      fill_in = fill_ff;
      if (cmd.fill_clr) begin
         fill_in = '0;
      end else if (cmd.fill_inc) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (cmd.fill_dec) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         act_ff <= action_type'(req_tdata[ACT_W-1:0]);
         pos_ff <= req_tdata[ACT_W +: POS_W];
         val_ff <= req_tdata[ACT_W+POS_W +: VAL_W];
         rv_ff  <= '0;
      end else if (cmd.cap_rv) begin
         rv_ff <= ram_rd_data;
      end
      if (cmd.init_idx) begin
         err_ff <= err_now;
         idx_ff <= (act_ff == ACT_INSERT) ? fill_ff : CNT_W'(pos_ff);
      end else if (cmd.wr_dn) begin
         idx_ff <= idx_ff - CNT_W'(1);
      end else if (cmd.wr_up) begin
         idx_ff <= idx_ff + CNT_W'(1);
      end
      if (cmd.load_out) begin
         rsp_data_ff <= {OUT_CNT_W'(fill_ff), rv_ff, err_ff};
      end
   end

   // Control registers; the store needs no clearing since reads stay below the length
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         if (cmd.load_out) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_data_ff);

   a_fill_cap: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(fill_ff) <= CMP_W'(CAPACITY))
      else $error("pal_dp: length above capacity");

   a_fill_inc: assert property (@(posedge clock) disable iff (reset)
      cmd.fill_inc |=> (fill_ff == $past(fill_ff) + CNT_W'(1)))
      else $error("pal_dp: insert did not grow the list by one");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !(rsp_tvalid_ff && !rsp_tready))
      else $error("pal_dp: result overwrote a beat not yet taken");

endmodule

`default_nettype wire

[design/positional_array_list_top.sv]
// Top level of the positional array list: stream ports, controller and datapath.
//
// A list of up to CAPACITY (64) signed 32-bit elements addressed by 1-based
// position, held in one RAM with a single write and a single registered read
// port. One request beat gives one response beat. Insert and delete shift the
// elements behind the position one at a time, each by a RAM read and then a
// write. A finished response sits in an output register so the next request
// can be taken while it waits. No clearing pass follows reset: slots past the
// current length are never read.
`default_nettype none

module positional_array_list_top
   import pal_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,  // action[1:0], position[8:2], value[40:9]
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic      [RSP_TDATA_W-1:0] rsp_tdata   // status[0], read_value[32:1], count[39:33]
);

   cmd_type  cmd;
   stat_type stat;

   pal_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   pal_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire
